@@ hdl/fdet_pkg.sv @@
// Shared types and constants for the frame difference event detector.
// No dependencies; imported by the top level, the frame store and the testbench.
package fdet_pkg;

  typedef logic [7:0] pix_t;
  typedef logic signed [8:0] diff_t;
  typedef logic [16:0] frame_len_t;

  // Configuration register indexes
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_FRAME_LEN = 1'b1;

  // Register reset values
  localparam pix_t THRESHOLD_RESET = 8'd35;
  localparam frame_len_t FRAME_LEN_RESET = 17'd65536;

endpackage

@@ hdl/fdet_frame_store.sv @@
// Previous-frame pixel store: one synchronous port, read-first, registered read data.
// Depends on fdet_pkg for the pixel type.
module fdet_frame_store import fdet_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  pix_t          wdata,
  output pix_t          rdata
);

  pix_t mem [DEPTH];

  // Read returns the old entry when the same address is written in the same cycle
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

@@ hdl/frame_difference_event_detector.sv @@
// Frame difference event detector top level: position counter, compare stage, output register.
// Depends on fdet_pkg and fdet_frame_store.
//
//   channel  handshake                 payload
//   -------  ------------------------  ---------------------------
//   pixel    pixel_valid/pixel_stall   luminance
//   event    event_valid/event_stall   change_value, frame_done
//   cfg      cfg_valid/cfg_ready       cfg_index, cfg_data
//
// One pixel per clock while pixel_stall is low; each result passes the compare stage, then the output register.
// The frame store port does one read and one write per pixel, so that port sets the rate.
// Reset clears the position, the first-frame flag and the registers; the store is not cleared.
// pixel_stall rises only when the compare stage and the output register are both full
// and the output is stalled. The first frame yields no results.
module frame_difference_event_detector import fdet_pkg::*; #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  pix_t        luminance,
  output logic        event_valid,
  input  logic        event_stall,
  output diff_t       change_value,
  output logic        frame_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  frame_len_t  cfg_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LW = (AW + 1 > 17) ? AW + 1 : 17;
  localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PIXELS);

  // Configuration registers
  pix_t       threshold;
  frame_len_t frame_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      frame_len <= FRAME_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[7:0];
        REG_FRAME_LEN: frame_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective frame length, clamped to 1..MAX_PIXELS
  logic [LW-1:0] len;
  logic [LW-1:0] len_ext;

  assign len_ext = LW'(frame_len);

  always_comb begin
    if (frame_len == '0) begin
      len = LW'(1);
    end else if (len_ext > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = len_ext;
    end
  end

  // Position within the frame and first-frame flag
  logic [AW-1:0] pos;
  logic          loaded;
  logic [AW-1:0] pos_eff;
  logic [AW-1:0] len_m1;
  logic          last;
  logic          accept;

  assign len_m1 = AW'(len - LW'(1));
  assign last = (LW'(pos) + LW'(1)) >= len;
  assign pos_eff = (LW'(pos) >= len) ? len_m1 : pos;
  assign accept = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      loaded <= 1'b0;
    end else if (accept) begin
      pos <= last ? '0 : AW'(pos_eff + AW'(1));
      if (last) begin
        loaded <= 1'b1;
      end
    end
  end

  // Frame store: read old pixel and write new one in the request cycle
  pix_t prev_pix;

  fdet_frame_store #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .en    (accept),
    .addr  (pos_eff),
    .wdata (luminance),
    .rdata (prev_pix)
  );

  // Compare stage, aligned with the store read data
  logic s1_valid;
  logic s1_emit;
  logic s1_last;
  pix_t s1_cur;
  logic out_free;
  logic s1_move;

  assign out_free = !event_valid || !event_stall;
  assign s1_move = !s1_valid || !s1_emit || out_free;
  assign pixel_stall = !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_move) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= loaded;
      s1_last <= last;
      s1_cur <= luminance;
    end
  end

  // Signed difference and threshold test
  diff_t       diff;
  logic [8:0]  mag;
  diff_t       result;

  assign diff = $signed({1'b0, s1_cur}) - $signed({1'b0, prev_pix});
  assign mag = diff[8] ? 9'(-diff) : 9'(diff);
  assign result = (mag > {1'b0, threshold}) ? diff : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_free) begin
      event_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && s1_emit) begin
      change_value <= result;
      frame_done <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // Input stalls only behind a full compare stage and a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> (s1_valid && s1_emit && event_valid && event_stall))
    else $error("pixel_stall without a blocked result");

  // Results only appear once the reference frame is loaded
  a_no_result_first_frame: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> loaded)
    else $error("result before reference frame loaded");

  // Pixels of the first frame never produce a result
  a_first_frame_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && !loaded) |=> (s1_valid && !s1_emit))
    else $error("first-frame pixel marked to emit");
`endif

endmodule

@@ tb/frame_difference_event_detector_tb.sv @@
// Self-checking testbench for frame_difference_event_detector: pixel stream in, events out.
// A scoreboard class predicts each event from its own copy of the frame store and registers.
// Depends on fdet_pkg and the frame_difference_event_detector RTL.
module frame_difference_event_detector_tb;
  import fdet_pkg::*;

  localparam int STORE_DEPTH = 65536;
  localparam int REF_PIXELS = 48;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SEGMENT_PIXELS = 125;
  localparam int MAX_PRINTED = 20;

  // Predicts events and holds the ones not yet seen
  class diff_scoreboard;
    pix_t ref_frame [STORE_DEPTH];
    int unsigned position;
    bit loaded;
    int unsigned threshold;
    int unsigned frame_len;
    diff_t want_change[$];
    bit want_done[$];
    int errors;

    function new();
      position = 0;
      loaded = 1'b0;
      threshold = THRESHOLD_RESET;
      frame_len = FRAME_LEN_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic idx, frame_len_t data);
      if (idx == REG_THRESHOLD) begin
        threshold = data[7:0];
      end else begin
        frame_len = data;
      end
    endfunction

    // Zero length acts as one, oversize clamps to the store
    function int unsigned active_len();
      int unsigned len;
      len = frame_len;
      if (len == 0) len = 1;
      if (len > STORE_DEPTH) len = STORE_DEPTH;
      return len;
    endfunction

    // Position past a shrunken frame end closes the frame
    function int unsigned slot();
      int unsigned p;
      int unsigned len;
      len = active_len();
      p = position;
      if (p >= len) p = len - 1;
      return p;
    endfunction

    function pix_t stored_at_next();
      return ref_frame[slot()];
    endfunction

    function int pending();
      return want_change.size();
    endfunction

    // Accepted pixel request: compare with stored pixel, then replace it
    function void take_pixel(pix_t cur);
      int unsigned p;
      bit last;
      int diff;
      int mag;
      p = slot();
      last = (p + 1 >= active_len());
      if (loaded) begin
        diff = int'(cur) - int'(ref_frame[p]);
        mag = (diff < 0) ? -diff : diff;
        want_change.push_back((mag > int'(threshold)) ? diff_t'(diff) : diff_t'(0));
        want_done.push_back(last);
      end
      ref_frame[p] = cur;
      if (last) begin
        position = 0;
        loaded = 1'b1;
      end else begin
        position = p + 1;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_event(diff_t got_change, logic got_done);
      diff_t exp_change;
      bit exp_done;
      if (want_change.size() == 0) begin
        report_mismatch($sformatf("event with nothing expected: change_value %0d frame_done %0b",
                                  got_change, got_done));
      end else begin
        exp_change = want_change.pop_front();
        exp_done = want_done.pop_front();
        if (got_change !== exp_change)
          report_mismatch($sformatf("change_value got %0d want %0d", got_change, exp_change));
        if (got_done !== exp_done)
          report_mismatch($sformatf("frame_done got %0b want %0b", got_done, exp_done));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic pixel_valid;
  logic pixel_stall;
  pix_t luminance;
  logic event_valid;
  logic event_stall;
  diff_t change_value;
  logic frame_done;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  frame_len_t cfg_data;

  int src_idle;
  int sink_stall;
  int hold_left;
  bit hold_req;
  diff_scoreboard sb = new();

  frame_difference_event_detector uut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .luminance(luminance),
    .event_valid(event_valid),
    .event_stall(event_stall),
    .change_value(change_value),
    .frame_done(frame_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Event side: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      event_stall <= 1'b1;
    end else begin
      event_stall <= ($urandom_range(99) < sink_stall);
    end
  end

  // Event monitor
  always @(posedge clk) begin
    if (!rst && event_valid && !event_stall) sb.check_event(change_value, frame_done);
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task send_pixel(input pix_t value);
    while ($urandom_range(99) < src_idle) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    luminance <= value;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sb.take_pixel(value);
    @(negedge clk);
  endtask

  // Sender pauses until every expected event is in, then lets the pipe settle
  task drain();
    pixel_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_cfg(input logic idx, input frame_len_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Both registers, then the write channel goes quiet
  task set_config(input frame_len_t thr_data, input frame_len_t len_data);
    write_cfg(REG_THRESHOLD, thr_data);
    write_cfg(REG_FRAME_LEN, len_data);
    cfg_valid <= 1'b0;
  endtask

  // Half the values near the threshold boundary of the stored pixel; the rest random, equal or full-scale
  function pix_t pick_pixel();
    int prev;
    int d;
    int v;
    int sel;
    prev = sb.stored_at_next();
    sel = $urandom_range(99);
    if (sel < 30) return pix_t'($urandom);
    if (sel < 80) begin
      d = int'(sb.threshold) + int'($urandom_range(2)) - 1;
      if ($urandom_range(1)) d = -d;
      v = prev + d;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return pix_t'(v);
    end
    if (sel < 90) return pix_t'(prev);
    return $urandom_range(1) ? 8'd255 : 8'd0;
  endfunction

  // Threshold with junk in the unused upper bits
  function frame_len_t pick_threshold();
    int sel;
    frame_len_t junk;
    sel = $urandom_range(99);
    junk = frame_len_t'($urandom) & 17'h1FF00;
    if (sel < 15) return junk;
    if (sel < 30) return junk | 17'd255;
    if (sel < 50) return junk | frame_len_t'($urandom_range(40));
    return junk | frame_len_t'($urandom_range(255));
  endfunction

  // Lengths stay within the reference frame, so every entry read was written
  function frame_len_t pick_frame_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 17'd0;
    if (sel < 20) return 17'd1;
    return frame_len_t'($urandom_range(REF_PIXELS, 2));
  endfunction

  task run_segment(input int count);
    repeat (count) send_pixel(pick_pixel());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    luminance = '0;
    event_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    src_idle = 0;
    sink_stall = 0;
    hold_left = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reference frame at the longest length used later, no events
    set_config(frame_len_t'(THRESHOLD_RESET), frame_len_t'(REF_PIXELS));
    repeat (REF_PIXELS) send_pixel(pix_t'($urandom));
    drain();

    // Zero threshold, full-scale swings both ways
    set_config(17'h1FF00, 17'd4);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();

    // Maximum threshold with zero length: every pixel ends a frame
    set_config(17'd255, 17'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    drain();
    set_config(17'd254, 17'd1);
    send_pixel(8'd0);
    drain();

    // Frame shrinks under the current position
    set_config(17'd35, 17'd8);
    repeat (5) send_pixel(pick_pixel());
    drain();
    set_config(17'd35, 17'd3);
    repeat (3) send_pixel(pick_pixel());
    drain();

    // Random traffic under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle = 0;
          sink_stall = 0;
        end
        1: begin
          src_idle = 64;
          sink_stall = 0;
        end
        2: begin
          src_idle = 0;
          sink_stall = 64;
        end
        default: begin
          src_idle = 6;
          sink_stall = 6;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        set_config(pick_threshold(), pick_frame_len());
        if (ph == 0 && seg == 0) hold_req = 1'b1;
        run_segment(SEGMENT_PIXELS);
      end
    end

    if (sb.errors == 0) begin
      $display("frame_difference_event_detector test passed");
    end else begin
      $display("frame_difference_event_detector test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("frame_difference_event_detector test failed");
    $finish;
  end

endmodule
